>>> hdl/cbq_pkg.sv
`default_nettype none

package cbq_pkg;

  localparam int MAX_SECTIONS   = 8;
  localparam int CHANNELS       = 2;
  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 30;
  localparam int NCOEF          = 6;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int RND_W  = PROD_W - COEF_FRAC_BITS;
  // Room for a value minus two rounded products, or a sum of three of them.
  localparam int ACC_W  = RND_W + 2;

  localparam int DLY_DEPTH  = CHANNELS * MAX_SECTIONS * 2;
  localparam int COEF_DEPTH = MAX_SECTIONS * NCOEF;
  localparam int DLY_AW     = $clog2(DLY_DEPTH);
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  localparam int CH_W     = 1;
  localparam int SEC_W    = 3;
  localparam int SEL_W    = 3;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 24;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  localparam logic [SEL_W-1:0] COEF_B0    = 3'd0;
  localparam logic [SEL_W-1:0] COEF_B1    = 3'd1;
  localparam logic [SEL_W-1:0] COEF_B2    = 3'd2;
  localparam logic [SEL_W-1:0] COEF_A1    = 3'd3;
  localparam logic [SEL_W-1:0] COEF_A2    = 3'd4;
  localparam logic [SEL_W-1:0] COEF_SCALE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MAX     = 2'd2;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [2:0] {
    MUL_DLY,
    MUL_W1,
    MUL_W2,
    MUL_W,
    MUL_ACC
  } mul_src_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_X_SUB,
    ACC_SUB,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    mul_src_e mul_src;
    acc_op_e  acc_op;
    logic     lat_w1;
    logic     lat_w2;
    logic     lat_w;
    logic     ld_x_in;
    logic     ld_x_rnd;
  } cbq_ctrl_t;

  // Round half up: floor((p + 2^(F-1)) / 2^F), which an arithmetic shift gives.
  function automatic logic signed [RND_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    return t[PROD_W-1:COEF_FRAC_BITS];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/cbq_ram.sv
`default_nettype none

module cbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/cbq_dp.sv
`default_nettype none

module cbq_dp (
  input  wire logic                                        clk_i,
  input  wire cbq_pkg::cbq_ctrl_t                          ctrl_i,
  input  wire logic signed [cbq_pkg::SAMPLE_WIDTH-1:0]     sample_i,
  input  wire logic        [cbq_pkg::DATA_W-1:0]           dly_rdata_i,
  input  wire logic        [cbq_pkg::DATA_W-1:0]           coef_rdata_i,
  output logic signed      [cbq_pkg::DATA_W-1:0]           x_o,
  output logic signed      [cbq_pkg::DATA_W-1:0]           w1_o,
  output logic signed      [cbq_pkg::DATA_W-1:0]           w_o
);

  import cbq_pkg::*;

  logic signed [DATA_W-1:0] x_q, w1_q, w2_q, w_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] p_q;
  logic signed [DATA_W-1:0] opnd, coef_s, acc_sat;
  logic signed [RND_W-1:0]  rnd_v;
  logic signed [ACC_W-1:0]  rnd_ext, x_ext;

  always_comb begin
    coef_s  = $signed(coef_rdata_i);
    acc_sat = sat32(acc_q);
    rnd_v   = round_prod(p_q);
    rnd_ext = {{(ACC_W-RND_W){rnd_v[RND_W-1]}}, rnd_v};
    x_ext   = {{(ACC_W-DATA_W){x_q[DATA_W-1]}}, x_q};
    case (ctrl_i.mul_src)
      MUL_DLY: opnd = $signed(dly_rdata_i);
      MUL_W1:  opnd = w1_q;
      MUL_W2:  opnd = w2_q;
      MUL_W:   opnd = w_q;
      MUL_ACC: opnd = acc_sat;
      default: opnd = '0;
    endcase
    case (ctrl_i.acc_op)
      ACC_X_SUB: acc_d = x_ext - rnd_ext;
      ACC_SUB:   acc_d = acc_q - rnd_ext;
      ACC_LOAD:  acc_d = rnd_ext;
      ACC_ADD:   acc_d = acc_q + rnd_ext;
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q   <= coef_s * opnd;
    acc_q <= acc_d;
    if (ctrl_i.lat_w1) begin
      w1_q <= $signed(dly_rdata_i);
    end
    if (ctrl_i.lat_w2) begin
      w2_q <= $signed(dly_rdata_i);
    end
    if (ctrl_i.lat_w) begin
      w_q <= acc_sat;
    end
    if (ctrl_i.ld_x_in) begin
      x_q <= {{(DATA_W-SAMPLE_WIDTH){sample_i[SAMPLE_WIDTH-1]}}, sample_i};
    end else if (ctrl_i.ld_x_rnd) begin
      x_q <= sat32(rnd_ext);
    end
  end

  assign x_o  = x_q;
  assign w1_o = w1_q;
  assign w_o  = w_q;

endmodule

`default_nettype wire

>>> hdl/cascaded_biquad_df2_filter.sv
// m_axis_tvalid rises once all N active sections of an accepted sample request have run, where N is the
// number of active sections; each section takes nine steps of the one shared 32x32 multiplier.
// One request is in work at a time, so no new request is taken until the result has gone to
// the output register; a coefficient write gives no result.
// Reset clears the control and configuration registers and the valid bits of both memories, so
// delays and coefficients read as zero at once; no clearing pass is needed.
`default_nettype none

module cascaded_biquad_df2_filter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_in[23:0], section[26:24], coef_select[29:27], coef_value[61:30]
  input  wire logic [63:0]                     s_axis_tdata,
  // req_type[0], channel[1]
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // sample_out[23:0]
  output logic [23:0]                          m_axis_tdata,
  // out_channel[0]
  output logic [0:0]                           m_axis_tuser,
  input  wire logic                            cfg_we_i,
  input  wire logic [cbq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [cbq_pkg::CFG_W-1:0]       cfg_wdata_i
);

  import cbq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  localparam logic [3:0] STEP_RD_W1 = 4'd0;
  localparam logic [3:0] STEP_RD_W2 = 4'd1;
  localparam logic [3:0] STEP_MUL_A2 = 4'd2;
  localparam logic [3:0] STEP_MUL_B1 = 4'd3;
  localparam logic [3:0] STEP_MUL_B2 = 4'd4;
  localparam logic [3:0] STEP_MUL_B0 = 4'd5;
  localparam logic [3:0] STEP_SUM_Y = 4'd6;
  localparam logic [3:0] STEP_MUL_SCALE = 4'd7;
  localparam logic [3:0] STEP_X = 4'd8;

  state_e                   state_q;
  logic [3:0]               step_q;
  logic [SEC_W-1:0]         sec_q;
  logic [CNT_W-1:0]         n_q;
  logic [CH_W-1:0]          ch_q;
  logic                     out_valid_q;
  logic [CH_W-1:0]          out_ch_q;
  logic [SAMPLE_WIDTH-1:0]  out_data_q;

  logic [CNT_W-1:0]               section_count_q;
  logic signed [SAMPLE_WIDTH-1:0] clamp_min_q, clamp_max_q;

  logic                     in_req;
  logic [CH_W-1:0]          in_ch;
  logic [SAMPLE_WIDTH-1:0]  in_sample;
  logic [SEC_W-1:0]         in_section;
  logic [SEL_W-1:0]         in_sel;
  logic [DATA_W-1:0]        in_coef;
  logic                     accept, sample_go;
  logic [CNT_W-1:0]         n_eff;

  cbq_ctrl_t                ctrl;
  logic                     dly_we, dly_re, coef_we, coef_re;
  logic [DLY_AW-1:0]        dly_base, dly_waddr, dly_raddr;
  logic [DATA_W-1:0]        dly_wdata, dly_rdata, coef_rdata;
  logic [COEF_AW-1:0]       coef_waddr, coef_raddr;
  logic [SEL_W-1:0]         rd_sel;
  logic signed [DATA_W-1:0] x_v, w1_v, w_v, clamp_v, cmin_ext, cmax_ext;
  logic                     last_sec;

  assign in_req     = s_axis_tuser[0];
  assign in_ch      = s_axis_tuser[1];
  assign in_sample  = s_axis_tdata[23:0];
  assign in_section = s_axis_tdata[26:24];
  assign in_sel     = s_axis_tdata[29:27];
  assign in_coef    = s_axis_tdata[61:30];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sample_go     = accept && (in_req == REQ_SAMPLE) && (int'(in_ch) < CHANNELS);
  assign n_eff = (int'(section_count_q) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                         : section_count_q;
  assign last_sec = (int'(sec_q) + 1 == int'(n_q));

  // Coefficient writes land only while idle, so they never meet a read of the running sample.
  assign coef_we    = accept && (in_req == REQ_COEF) && (int'(in_sel) < NCOEF)
                      && (int'(in_section) < MAX_SECTIONS);
  assign coef_waddr = COEF_AW'(int'(in_section) * NCOEF + int'(in_sel));

  assign dly_base = DLY_AW'((int'(ch_q) * MAX_SECTIONS + int'(sec_q)) * 2);

  // Step schedule of one section. Reads of w1/w2 happen before their write-back, and each
  // section owns distinct delay entries, so no two accesses to one entry overlap.
  always_comb begin
    ctrl          = '0;
    ctrl.mul_src  = MUL_DLY;
    ctrl.acc_op   = ACC_HOLD;
    ctrl.ld_x_in  = sample_go;
    dly_re        = 1'b0;
    dly_raddr     = dly_base;
    dly_we        = 1'b0;
    dly_waddr     = dly_base;
    dly_wdata     = w_v;
    coef_re       = 1'b0;
    rd_sel        = COEF_A1;
    if (state_q == ST_RUN) begin
      case (step_q)
        STEP_RD_W1: begin
          dly_re  = 1'b1;
          coef_re = 1'b1;
          rd_sel  = COEF_A1;
        end
        STEP_RD_W2: begin
          dly_re      = 1'b1;
          dly_raddr   = dly_base + DLY_AW'(1);
          coef_re     = 1'b1;
          rd_sel      = COEF_A2;
          ctrl.lat_w1 = 1'b1;
        end
        STEP_MUL_A2: begin
          coef_re     = 1'b1;
          rd_sel      = COEF_B1;
          ctrl.lat_w2 = 1'b1;
          ctrl.acc_op = ACC_X_SUB;
        end
        STEP_MUL_B1: begin
          coef_re      = 1'b1;
          rd_sel       = COEF_B2;
          ctrl.mul_src = MUL_W1;
          ctrl.acc_op  = ACC_SUB;
        end
        STEP_MUL_B2: begin
          coef_re      = 1'b1;
          rd_sel       = COEF_B0;
          ctrl.mul_src = MUL_W2;
          ctrl.lat_w   = 1'b1;
          ctrl.acc_op  = ACC_LOAD;
          dly_we       = 1'b1;
          dly_waddr    = dly_base + DLY_AW'(1);
          dly_wdata    = w1_v;
        end
        STEP_MUL_B0: begin
          coef_re      = 1'b1;
          rd_sel       = COEF_SCALE;
          ctrl.mul_src = MUL_W;
          ctrl.acc_op  = ACC_ADD;
          dly_we       = 1'b1;
        end
        STEP_SUM_Y: begin
          ctrl.acc_op = ACC_ADD;
        end
        STEP_MUL_SCALE: begin
          ctrl.mul_src = MUL_ACC;
        end
        STEP_X: begin
          ctrl.ld_x_rnd = 1'b1;
        end
        default: begin
          ctrl.acc_op = ACC_HOLD;
        end
      endcase
    end
  end

  assign coef_raddr = COEF_AW'(int'(sec_q) * NCOEF + int'(rd_sel));

  cbq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DLY_DEPTH)
  ) u_dly_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (dly_we),
    .waddr_i(dly_waddr),
    .wdata_i(dly_wdata),
    .re_i   (dly_re),
    .raddr_i(dly_raddr),
    .rdata_o(dly_rdata)
  );

  cbq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(COEF_DEPTH)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(in_coef),
    .re_i   (coef_re),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  cbq_dp u_dp (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .sample_i    ($signed(in_sample)),
    .dly_rdata_i (dly_rdata),
    .coef_rdata_i(coef_rdata),
    .x_o         (x_v),
    .w1_o        (w1_v),
    .w_o         (w_v)
  );

  // With crossed bounds the lower bound wins.
  always_comb begin
    cmin_ext = {{(DATA_W-SAMPLE_WIDTH){clamp_min_q[SAMPLE_WIDTH-1]}}, clamp_min_q};
    cmax_ext = {{(DATA_W-SAMPLE_WIDTH){clamp_max_q[SAMPLE_WIDTH-1]}}, clamp_max_q};
    clamp_v  = (x_v > cmax_ext) ? cmax_ext : x_v;
    if (clamp_v < cmin_ext) begin
      clamp_v = cmin_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_count_q <= '0;
      clamp_min_q     <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      clamp_max_q     <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SECTION_COUNT: section_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_CLAMP_MIN:     clamp_min_q     <= $signed(cfg_wdata_i[SAMPLE_WIDTH-1:0]);
        CFG_CLAMP_MAX:     clamp_max_q     <= $signed(cfg_wdata_i[SAMPLE_WIDTH-1:0]);
        default:           section_count_q <= section_count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_RD_W1;
      sec_q       <= '0;
      n_q         <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      out_ch_q    <= '0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (sample_go) begin
            ch_q    <= in_ch;
            n_q     <= n_eff;
            sec_q   <= '0;
            step_q  <= STEP_RD_W1;
            state_q <= (n_eff == '0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_q == STEP_X) begin
            step_q <= STEP_RD_W1;
            if (last_sec) begin
              state_q <= ST_DONE;
            end else begin
              sec_q <= sec_q + SEC_W'(1);
            end
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_ch_q    <= ch_q;
            out_data_q  <= clamp_v[SAMPLE_WIDTH-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ch_q;

  a_dly_write_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dly_we |-> state_q == ST_RUN)
    else $error("delay write outside of a running request");

  a_coef_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_we |-> state_q == ST_IDLE)
    else $error("coefficient write while a sample is in work");

  a_section_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (int'(sec_q) < int'(n_q)) && (step_q <= STEP_X))
    else $error("section or step counter past its end");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without finishing a request");

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;

  import cbq_pkg::*;

  // Longest sample latency plus margin. It covers a request still in work after the last result.
  localparam int IDLE_GUARD  = 9 * MAX_SECTIONS + 12;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 400;

  // Select codes with no coefficient behind them.
  localparam logic [SEL_W-1:0] SEL_UNUSED_LO = 3'd6;
  localparam logic [SEL_W-1:0] SEL_UNUSED_HI = 3'd7;

  typedef struct {
    logic                           req;
    logic                           ch;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic [SEC_W-1:0]               sec;
    logic [SEL_W-1:0]               sel;
    logic signed [DATA_W-1:0]       cval;
  } biquad_req_t;

  typedef struct {
    logic                    ch;
    logic [SAMPLE_WIDTH-1:0] smp;
  } filtered_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // sample_in[23:0], section[26:24], coef_select[29:27], coef_value[61:30]
  logic [63:0]          s_axis_tdata  = '0;
  // req_type[0], channel[1]
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // sample_out[23:0]
  logic [23:0]          m_axis_tdata;
  // out_channel[0]
  logic [0:0]           m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;

  // Filter state as the block should hold it.
  logic signed [DATA_W-1:0]       coef_mem [MAX_SECTIONS][NCOEF];
  logic signed [DATA_W-1:0]       dly_w1 [CHANNELS][MAX_SECTIONS];
  logic signed [DATA_W-1:0]       dly_w2 [CHANNELS][MAX_SECTIONS];
  logic [CNT_W-1:0]               n_sections = '0;
  logic signed [SAMPLE_WIDTH-1:0] lo_bound   = -24'sd8388608;
  logic signed [SAMPLE_WIDTH-1:0] hi_bound   = 24'sd8388607;

  filtered_t expected_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int err_count      = 0;
  int n_checked      = 0;
  int n_samples      = 0;
  int n_coef         = 0;
  int n_settings     = 0;

  cascaded_biquad_df2_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int s = 0; s < MAX_SECTIONS; s++) begin
        dly_w1[c][s] = '0;
        dly_w2[c][s] = '0;
      end
    end
    for (int s = 0; s < MAX_SECTIONS; s++) begin
      for (int k = 0; k < NCOEF; k++) begin
        coef_mem[s][k] = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Rounded Q2.30 product; the arithmetic shift floors, so halves round up.
  function automatic longint rnd_mul(input longint c, input longint v);
    longint t;
    t = c * v + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    return t >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
    if (v < longint'(32'sh80000000)) return longint'(32'sh80000000);
    return v;
  endfunction

  task automatic apply_request(input biquad_req_t r);
    longint    x, w1, w2, w, y;
    int        n;
    filtered_t res;
    if (r.req == REQ_COEF) begin
      n_coef++;
      if (r.sel < NCOEF) coef_mem[r.sec][r.sel] = r.cval;
      return;
    end
    n_samples++;
    n = (n_sections > MAX_SECTIONS) ? MAX_SECTIONS : int'(n_sections);
    x = longint'(r.smp);
    for (int s = 0; s < n; s++) begin
      w1 = longint'(dly_w1[r.ch][s]);
      w2 = longint'(dly_w2[r.ch][s]);
      w  = clip32(x - rnd_mul(coef_mem[s][COEF_A1], w1) - rnd_mul(coef_mem[s][COEF_A2], w2));
      y  = clip32(rnd_mul(coef_mem[s][COEF_B0], w) + rnd_mul(coef_mem[s][COEF_B1], w1)
                  + rnd_mul(coef_mem[s][COEF_B2], w2));
      x  = clip32(rnd_mul(coef_mem[s][COEF_SCALE], y));
      dly_w2[r.ch][s] = DATA_W'(w1);
      dly_w1[r.ch][s] = DATA_W'(w);
    end
    // Upper bound first, so crossed bounds leave the lower one.
    if (x > hi_bound) x = longint'(hi_bound);
    if (x < lo_bound) x = longint'(lo_bound);
    res.ch  = r.ch;
    res.smp = x[SAMPLE_WIDTH-1:0];
    expected_q.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stalls, long hold-off and result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint want, input longint got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic check_result(input logic ch, input logic [SAMPLE_WIDTH-1:0] smp);
    filtered_t want;
    if (expected_q.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("Unexpected result: channel %0d, sample %0d", ch, $signed(smp));
      end
      return;
    end
    want = expected_q.pop_front();
    n_checked++;
    if (ch !== want.ch) report_mismatch("channel", longint'(want.ch), longint'(ch));
    if (smp !== want.smp) begin
      report_mismatch("sample", longint'($signed(want.smp)), longint'($signed(smp)));
    end
  endtask

  // The long hold-off is counted here, one step per clock.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    <= hold_request;
      hold_request = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tuser[0], m_axis_tdata);
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic biquad_req_t make_sample(input logic ch,
                                              input logic signed [SAMPLE_WIDTH-1:0] v);
    biquad_req_t r;
    r.req  = REQ_SAMPLE;
    r.ch   = ch;
    r.smp  = v;
    r.sec  = SEC_W'($urandom);
    r.sel  = SEL_W'($urandom);
    r.cval = $urandom;
    return r;
  endfunction

  function automatic biquad_req_t make_coef(input logic [SEC_W-1:0] sec,
                                            input logic [SEL_W-1:0] sel,
                                            input logic signed [DATA_W-1:0] v);
    biquad_req_t r;
    r.req  = REQ_COEF;
    r.ch   = 1'($urandom);
    r.smp  = SAMPLE_WIDTH'($urandom);
    r.sec  = sec;
    r.sel  = sel;
    r.cval = v;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    int p;
    p = $urandom_range(99);
    if (p < 10) return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    if (p < 30) return SAMPLE_WIDTH'($urandom);
    return SAMPLE_WIDTH'($urandom_range(2097151) - 1048576);
  endfunction

  function automatic int rand_milli(input int lo, input int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic logic signed [DATA_W-1:0] q30(input int milli);
    return DATA_W'((longint'(milli) <<< COEF_FRAC_BITS) / 1000);
  endfunction

  // The request is presented until accepted; valid stays high into the next request unless an idle gap is drawn.
  task automatic send_item(input biquad_req_t r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, r.cval, r.sel, r.sec, r.smp};
    s_axis_tuser  <= {r.ch, r.req};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(r);
  endtask

  task automatic wait_idle(input int guard);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (guard) @(posedge clk_i);
  endtask

  // Write enable stays high across the three back-to-back register writes.
  task automatic program_registers(input logic [CNT_W-1:0] count,
                                   input logic signed [CFG_W-1:0] lo,
                                   input logic signed [CFG_W-1:0] hi);
    wait_idle(IDLE_GUARD);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SECTION_COUNT;
    cfg_wdata_i <= CFG_W'(count);
    @(posedge clk_i);
    n_sections = count;
    cfg_index_i <= CFG_CLAMP_MIN;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    lo_bound = lo;
    cfg_index_i <= CFG_CLAMP_MAX;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    hi_bound = hi;
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Loads one section with a stable pole pair: |a2| < 1 and |a1| < 1 + a2.
  task automatic program_section(input int s);
    int a2m, lim;
    a2m = rand_milli(-900, 900);
    lim = (1000 + a2m) * 95 / 100;
    send_item(make_coef(SEC_W'(s), COEF_B0, q30(rand_milli(-1000, 1000))));
    send_item(make_coef(SEC_W'(s), COEF_B1, q30(rand_milli(-1000, 1000))));
    send_item(make_coef(SEC_W'(s), COEF_B2, q30(rand_milli(-1000, 1000))));
    send_item(make_coef(SEC_W'(s), COEF_A1, q30(rand_milli(-lim, lim))));
    send_item(make_coef(SEC_W'(s), COEF_A2, q30(a2m)));
    send_item(make_coef(SEC_W'(s), COEF_SCALE, q30(rand_milli(-1500, 1500))));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset no section is active, so samples only pass the clamp.
  task automatic test_passthrough();
    send_item(make_sample(1'b0, 24'sh7FFFFF));
    send_item(make_sample(1'b1, 24'sh800000));
    send_item(make_sample(1'b0, 24'sh000000));
  endtask

  task automatic test_coef_extremes();
    send_item(make_coef(3'd0, SEL_UNUSED_LO, 32'sh40000000));
    send_item(make_coef(3'd0, SEL_UNUSED_HI, 32'sh40000000));
    // Gains near +2 and feedback at -2 drive the delays and the sums into saturation.
    send_item(make_coef(3'd0, COEF_B0, 32'sh7FFFFFFF));
    send_item(make_coef(3'd0, COEF_A1, 32'sh80000000));
    send_item(make_coef(3'd0, COEF_A2, 32'sh80000000));
    send_item(make_coef(3'd0, COEF_SCALE, 32'sh7FFFFFFF));
    send_item(make_coef(3'd1, COEF_B0, 32'sh7FFFFFFF));
    send_item(make_coef(3'd1, COEF_SCALE, 32'sh7FFFFFFF));
    program_registers(4'd2, -24'sd8388608, 24'sd8388607);
    repeat (3) send_item(make_sample(1'b0, 24'sh7FFFFF));
    repeat (2) send_item(make_sample(1'b1, 24'sh800000));
    // A count above the number of sections acts as all of them.
    program_registers(4'd15, -24'sd8388608, 24'sd8388607);
    send_item(make_sample(1'b0, 24'sh7FFFFF));
  endtask

  task automatic test_clamp_bounds();
    // Crossed bounds: the lower bound wins.
    program_registers(4'd0, 24'sd8388607, -24'sd8388608);
    send_item(make_sample(1'b0, 24'sh000000));
    send_item(make_sample(1'b1, 24'sh800000));
    program_registers(4'd0, -24'sd1000, 24'sd1000);
    send_item(make_sample(1'b0, 24'sh7FFFFF));
    send_item(make_sample(1'b1, 24'sh800000));
    send_item(make_sample(1'b0, 24'sd500));
  endtask

  // Programs the active sections, then mostly sample bursts, with some section reprograms and stray
  // coefficient writes mixed in.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [CNT_W-1:0] count, input int n_items);
    logic signed [CFG_W-1:0] lo, hi;
    int          active, done, pick, burst, m, s;
    biquad_req_t r;
    case ($urandom_range(3))
      0: begin
        m  = $urandom_range(4000000, 1);
        lo = CFG_W'(-m);
        hi = CFG_W'(m);
      end
      1: begin
        lo = CFG_W'($urandom);
        hi = CFG_W'($urandom);
      end
      default: begin
        lo = -24'sd8388608;
        hi = 24'sd8388607;
      end
    endcase
    program_registers(count, lo, hi);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    active = (count > MAX_SECTIONS) ? MAX_SECTIONS : int'(count);
    done   = 0;
    for (s = 0; s < active; s++) begin
      program_section(s);
      done += NCOEF;
    end
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        program_section($urandom_range(MAX_SECTIONS - 1));
        done += NCOEF;
      end else if (pick < 14) begin
        r = make_coef(SEC_W'($urandom), SEL_W'($urandom), $urandom);
        send_item(r);
        if (r.sel < NCOEF) done++;
      end else begin
        burst = $urandom_range(12, 1);
        repeat (burst) send_item(make_sample(1'($urandom), pick_sample()));
        done += burst;
      end
    end
  endtask

  // The output is held off long enough that the block stops taking requests.
  task automatic test_backpressure();
    program_registers(4'd3, -24'sd8388608, 24'sd8388607);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    repeat (30) send_item(make_sample(1'($urandom), pick_sample()));
    wait_idle(1);
    repeat (10) send_item(make_sample(1'($urandom), pick_sample()));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_coef_extremes();
    test_clamp_bounds();
    test_random_traffic(0, 0, 4'd2, 240);
    test_random_traffic(0, 0, 4'd8, 240);
    test_random_traffic(87, 0, 4'd15, 240);
    test_random_traffic(87, 0, 4'd1, 240);
    test_random_traffic(0, 87, 4'd0, 240);
    test_random_traffic(0, 87, 4'd5, 240);
    test_random_traffic(26, 26, 4'($urandom_range(12, 3)), 240);
    test_random_traffic(26, 26, 4'd3, 240);
    test_backpressure();

    wait_idle(IDLE_GUARD);
    $display("Filtered %0d samples and applied %0d coefficient writes under %0d register settings,",
             n_samples, n_coef, n_settings);
    $display("with input gaps, output stalls and a long output hold-off; %0d results compared.",
             n_checked);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results still pending", expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

>>> cascaded_biquad_df2_filter.f
hdl/cbq_pkg.sv
hdl/cbq_ram.sv
hdl/cbq_dp.sv
hdl/cascaded_biquad_df2_filter.sv
dv/testbench.sv
